// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/trpq_pkg.sv =====
// ----------------------------------------------------------------------------
// trpq_pkg
// Constants and types of the timed repeat publish queue.
// ----------------------------------------------------------------------------
package trpq_pkg;

    // Table geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = IDX_W + 1;

    // Configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam int REG_W  = 1;
    localparam logic [REG_W-1:0] REG_REPEAT_COUNT    = 1'd0;
    localparam logic [REG_W-1:0] REG_REPEAT_INTERVAL = 1'd1;
    localparam logic [3:0]  REPEAT_COUNT_RST    = 4'd2;
    localparam logic [15:0] REPEAT_INTERVAL_RST = 16'd20;

    // Request and result codes
    localparam logic REQ_TICK     = 1'b0;
    localparam logic REQ_PUBLISH  = 1'b1;
    localparam logic KIND_STATUS  = 1'b0;
    localparam logic KIND_MESSAGE = 1'b1;
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_DROP  = 1'b1;

    // One scheduled table entry
    typedef struct packed {
        logic [31:0] due;
        logic [1:0]  op;
        logic [15:0] id;
        logic        onoff;
        logic [7:0]  tid;
        logic [15:0] transition;
        logic [15:0] delay;
        logic [3:0]  copy;
    } slot_t;

endpackage

// ===== rtl/core/timed_repeat_publish_queue.sv =====
// ----------------------------------------------------------------------------
// timed_repeat_publish_queue
// Table of scheduled messages held in a synchronous memory with a registered read.
// ----------------------------------------------------------------------------
// Publish: one table write per copy, status result strobed in the cycle after the
//   last write; busy holds off new requests until the status is strobed.
// Tick: one memory read per slot over all 16 slots; each due entry is held until
//   the next due one is found, the last one after the scan ends.
// Reset clears valid bits, transaction id and control and configuration registers;
// memory and payload registers are not cleared. Results are strobed for one cycle; the receiver cannot stall.
`include "assert_macros.svh"

module timed_repeat_publish_queue
(
    input  logic                               clk,
    input  logic                               rst_n,
    // command channel
    input  logic                               start,
    output logic                               busy,
    input  logic                               req_type,
    input  logic [31:0]                        now_ms,
    input  logic [1:0]                         msg_op,
    input  logic [15:0]                        target_id,
    input  logic                               onoff,
    input  logic [15:0]                        transition_ms,
    input  logic [15:0]                        delay_ms,
    // result channel
    output logic                               result_valid,
    output logic                               result_kind,
    output logic                               status,
    output logic [1:0]                         out_op,
    output logic [15:0]                        out_id,
    output logic                               out_onoff,
    output logic [7:0]                         out_tid,
    output logic [15:0]                        out_transition,
    output logic [15:0]                        out_delay,
    output logic [3:0]                         copy_index,
    output logic                               last,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [trpq_pkg::ADDR_W-1:0]        paddr,
    input  logic [trpq_pkg::DATA_W-1:0]        pwdata,
    output logic [trpq_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_PUB   = 4'b0010,
        S_SCAN  = 4'b0100,
        S_FLUSH = 4'b1000
    } state_t;

    localparam logic [trpq_pkg::IDX_W-1:0] IDX_MAX  = trpq_pkg::IDX_W'(trpq_pkg::QUEUE_DEPTH - 1);
    localparam logic [trpq_pkg::CNT_W-1:0] SCAN_END = trpq_pkg::CNT_W'(trpq_pkg::QUEUE_DEPTH);

    // control registers
    state_t                              state_reg, state_next;
    logic [3:0]                          repeat_count_reg;
    logic [15:0]                         repeat_interval_reg;
    logic [7:0]                          tid_reg, tid_next;
    logic [trpq_pkg::QUEUE_DEPTH-1:0]    valid_reg, valid_next;
    logic [trpq_pkg::CNT_W-1:0]          scan_reg, scan_next;
    logic                                chk_vld_reg, chk_vld_next;
    logic [trpq_pkg::IDX_W-1:0]          chk_idx_reg, chk_idx_next;
    logic                                pend_vld_reg, pend_vld_next;
    logic                                res_vld_reg, res_vld_next;

    // payload registers
    trpq_pkg::slot_t                     req_reg, req_next;
    logic [3:0]                          copy_reg, copy_next;
    trpq_pkg::slot_t                     pend_reg, pend_next;
    trpq_pkg::slot_t                     res_slot_reg, res_slot_next;
    logic                                res_kind_reg, res_kind_next;
    logic                                res_status_reg, res_status_next;
    logic                                res_last_reg, res_last_next;

    // slot memory
    trpq_pkg::slot_t                     mem [trpq_pkg::QUEUE_DEPTH];
    trpq_pkg::slot_t                     rd_data_reg;
    logic                                mem_we;
    logic [trpq_pkg::IDX_W-1:0]          mem_waddr;
    trpq_pkg::slot_t                     mem_wdata;
    logic                                mem_re;
    logic [trpq_pkg::IDX_W-1:0]          mem_raddr;

    logic                                free_found;
    logic [trpq_pkg::IDX_W-1:0]          free_idx;
    logic                                hit;
    logic                                cfg_write;
    logic [trpq_pkg::REG_W-1:0]          cfg_sel;

    // Configuration access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = paddr[trpq_pkg::ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repeat_count_reg    <= trpq_pkg::REPEAT_COUNT_RST;
            repeat_interval_reg <= trpq_pkg::REPEAT_INTERVAL_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                trpq_pkg::REG_REPEAT_COUNT:    repeat_count_reg    <= pwdata[3:0];
                trpq_pkg::REG_REPEAT_INTERVAL: repeat_interval_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            trpq_pkg::REG_REPEAT_COUNT:
                prdata = {(trpq_pkg::DATA_W - 4)'(0), repeat_count_reg};
            trpq_pkg::REG_REPEAT_INTERVAL:
                prdata = {(trpq_pkg::DATA_W - 16)'(0), repeat_interval_reg};
            default:
                prdata = '0;
        endcase
    end

    // Find the lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = trpq_pkg::QUEUE_DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = trpq_pkg::IDX_W'(i);
            end
        end
    end

    // Due check on the entry read in the previous cycle
    assign hit = chk_vld_reg && valid_reg[chk_idx_reg] && (req_reg.due >= rd_data_reg.due);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        tid_next        = tid_reg;
        valid_next      = valid_reg;
        scan_next       = scan_reg;
        chk_vld_next    = 1'b0;
        chk_idx_next    = chk_idx_reg;
        pend_vld_next   = pend_vld_reg;
        res_vld_next    = 1'b0;
        req_next        = req_reg;
        copy_next       = copy_reg;
        pend_next       = pend_reg;
        res_slot_next   = res_slot_reg;
        res_kind_next   = res_kind_reg;
        res_status_next = res_status_reg;
        res_last_next   = res_last_reg;
        mem_we          = 1'b0;
        mem_waddr       = free_idx;
        mem_wdata       = req_reg;
        mem_re          = 1'b0;
        mem_raddr       = scan_reg[trpq_pkg::IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    // capture the request; due holds the running time
                    req_next.due        = now_ms;
                    req_next.op         = msg_op;
                    req_next.id         = target_id;
                    req_next.onoff      = onoff;
                    req_next.tid        = tid_reg + 8'd1;
                    req_next.transition = transition_ms;
                    req_next.delay      = delay_ms;
                    req_next.copy       = 4'd0;
                    if (req_type == trpq_pkg::REQ_PUBLISH)
                    begin
                        tid_next   = tid_reg + 8'd1;
                        copy_next  = 4'd0;
                        state_next = S_PUB;
                    end
                    else
                    begin
                        scan_next     = '0;
                        pend_vld_next = 1'b0;
                        state_next    = S_SCAN;
                    end
                end
            end

            S_PUB:
            begin
                res_kind_next      = trpq_pkg::KIND_STATUS;
                res_slot_next      = '0;
                res_slot_next.tid  = tid_reg;
                res_last_next      = 1'b1;
                if (free_found)
                begin
                    // place one copy in the lowest free slot
                    mem_we                = 1'b1;
                    mem_wdata.copy        = copy_reg;
                    valid_next[free_idx]  = 1'b1;
                    if (copy_reg == repeat_count_reg)
                    begin
                        res_vld_next    = 1'b1;
                        res_status_next = trpq_pkg::STATUS_OK;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        copy_next    = copy_reg + 4'd1;
                        req_next.due = req_reg.due + {16'd0, repeat_interval_reg};
                    end
                end
                else
                begin
                    // table full: drop the remaining copies
                    res_vld_next    = 1'b1;
                    res_status_next = trpq_pkg::STATUS_DROP;
                    state_next      = S_IDLE;
                end
            end

            S_SCAN:
            begin
                // issue the next slot read
                if (scan_reg < SCAN_END)
                begin
                    mem_re       = 1'b1;
                    chk_vld_next = 1'b1;
                    chk_idx_next = scan_reg[trpq_pkg::IDX_W-1:0];
                    scan_next    = scan_reg + trpq_pkg::CNT_W'(1);
                end
                // free a due entry, release the one held before it
                if (hit)
                begin
                    valid_next[chk_idx_reg] = 1'b0;
                    if (pend_vld_reg)
                    begin
                        res_vld_next    = 1'b1;
                        res_kind_next   = trpq_pkg::KIND_MESSAGE;
                        res_status_next = trpq_pkg::STATUS_OK;
                        res_slot_next   = pend_reg;
                        res_last_next   = 1'b0;
                    end
                    pend_next     = rd_data_reg;
                    pend_vld_next = 1'b1;
                end
                if (chk_vld_reg && (chk_idx_reg == IDX_MAX))
                begin
                    state_next = S_FLUSH;
                end
            end

            S_FLUSH:
            begin
                // release the final due entry flagged as last
                if (pend_vld_reg)
                begin
                    res_vld_next    = 1'b1;
                    res_kind_next   = trpq_pkg::KIND_MESSAGE;
                    res_status_next = trpq_pkg::STATUS_OK;
                    res_slot_next   = pend_reg;
                    res_last_next   = 1'b1;
                end
                pend_vld_next = 1'b0;
                state_next    = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            tid_reg      <= '0;
            valid_reg    <= '0;
            scan_reg     <= '0;
            chk_vld_reg  <= 1'b0;
            chk_idx_reg  <= '0;
            pend_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            tid_reg      <= tid_next;
            valid_reg    <= valid_next;
            scan_reg     <= scan_next;
            chk_vld_reg  <= chk_vld_next;
            chk_idx_reg  <= chk_idx_next;
            pend_vld_reg <= pend_vld_next;
            res_vld_reg  <= res_vld_next;
        end
    end

    // Payload state
    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        copy_reg       <= copy_next;
        pend_reg       <= pend_next;
        res_slot_reg   <= res_slot_next;
        res_kind_reg   <= res_kind_next;
        res_status_reg <= res_status_next;
        res_last_reg   <= res_last_next;
    end

    // Slot memory: one write or one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // Drive outputs
    assign busy           = (state_reg != S_IDLE);
    assign result_valid   = res_vld_reg;
    assign result_kind    = res_kind_reg;
    assign status         = res_status_reg;
    assign out_op         = res_slot_reg.op;
    assign out_id         = res_slot_reg.id;
    assign out_onoff      = res_slot_reg.onoff;
    assign out_tid        = res_slot_reg.tid;
    assign out_transition = res_slot_reg.transition;
    assign out_delay      = res_slot_reg.delay;
    assign copy_index     = res_slot_reg.copy;
    assign last           = res_last_reg;

    // Assertions
    `ASSERT_NEXT(a_full_drops, clk, rst_n, (state_reg == S_PUB) && !free_found, result_valid && (status == trpq_pkg::STATUS_DROP))
    `ASSERT_IMPLIES(a_idle_no_write, clk, rst_n, !busy, !mem_we)
    `ASSERT_NEXT(a_last_gap, clk, rst_n, result_valid && last, !result_valid)

endmodule

// ===== sim/publish_queue_checker.sv =====
// ----------------------------------------------------------------------------
// publish_queue_checker
// Watches the command, result and register channels of the publish queue.
// Keeps its own copy of the schedule table and registers, works out every
// result an accepted command causes, and compares each strobed result field
// by field against the oldest outstanding one. Register reads are checked
// against the tracked register values.
// ----------------------------------------------------------------------------
module publish_queue_checker
    import trpq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic              req_type,
    input  logic [31:0]       now_ms,
    input  logic [1:0]        msg_op,
    input  logic [15:0]       target_id,
    input  logic              onoff,
    input  logic [15:0]       transition_ms,
    input  logic [15:0]       delay_ms,
    input  logic              result_valid,
    input  logic              result_kind,
    input  logic              status,
    input  logic [1:0]        out_op,
    input  logic [15:0]       out_id,
    input  logic              out_onoff,
    input  logic [7:0]        out_tid,
    input  logic [15:0]       out_transition,
    input  logic [15:0]       out_delay,
    input  logic [3:0]        copy_index,
    input  logic              last,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic [DATA_W-1:0] prdata,
    input  logic              pready,
    output int                fail_count,
    output int                pending,
    output int                checked
);

    // One result as it appears on the result ports
    typedef struct packed {
        logic        kind;
        logic        stat;
        logic [1:0]  op;
        logic [15:0] id;
        logic        onoff;
        logic [7:0]  tid;
        logic [15:0] transition;
        logic [15:0] delay;
        logic [3:0]  copy;
        logic        last;
    } outcome_t;

    // Tracked table, registers and outstanding results
    slot_t                  sched[QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] sched_live;
    logic [7:0]             tid_ctr;
    logic [3:0]             rpt_count;
    logic [15:0]            rpt_interval;
    outcome_t               awaited[$];
    outcome_t               got;
    outcome_t               want;
    logic [DATA_W-1:0]      reg_value;
    int                     errs;
    int                     n_checked;

    function automatic int first_free();
        for (int i = 0; i < QUEUE_DEPTH; i++)
            if (!sched_live[i])
                return i;
        return -1;
    endfunction

    // Bump the transaction id, place the copies, queue the status result
    task automatic place_copies(input logic [31:0] now, input logic [1:0] op,
                                input logic [15:0] id, input logic oo,
                                input logic [15:0] tr, input logic [15:0] dl);
        outcome_t res;
        logic     dropped;
        int       s;
        dropped = STATUS_OK;
        tid_ctr = tid_ctr + 8'd1;
        for (int c = 0; c <= rpt_count; c++) begin
            s = first_free();
            if (s < 0) begin
                dropped = STATUS_DROP;
                break;
            end
            sched_live[s]       = 1'b1;
            sched[s].due        = now + 32'(c) * 32'(rpt_interval);
            sched[s].op         = op;
            sched[s].id         = id;
            sched[s].onoff      = oo;
            sched[s].tid        = tid_ctr;
            sched[s].transition = tr;
            sched[s].delay      = dl;
            sched[s].copy       = 4'(c);
        end
        res      = '0;
        res.kind = KIND_STATUS;
        res.stat = dropped;
        res.tid  = tid_ctr;
        res.last = 1'b1;
        awaited.push_back(res);
    endtask

    // Emit and free every live entry whose due time has been reached
    task automatic release_due(input logic [31:0] now);
        outcome_t res;
        int       final_slot;
        final_slot = -1;
        for (int i = 0; i < QUEUE_DEPTH; i++)
            if (sched_live[i] && now >= sched[i].due)
                final_slot = i;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (sched_live[i] && now >= sched[i].due) begin
                res.kind       = KIND_MESSAGE;
                res.stat       = STATUS_OK;
                res.op         = sched[i].op;
                res.id         = sched[i].id;
                res.onoff      = sched[i].onoff;
                res.tid        = sched[i].tid;
                res.transition = sched[i].transition;
                res.delay      = sched[i].delay;
                res.copy       = sched[i].copy;
                res.last       = (i == final_slot);
                sched_live[i]  = 1'b0;
                awaited.push_back(res);
            end
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s expected %0h, got %0h", $time, what, exp_v, act_v);
            errs++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            sched_live   = '0;
            tid_ctr      = '0;
            rpt_count    = REPEAT_COUNT_RST;
            rpt_interval = REPEAT_INTERVAL_RST;
            errs         = 0;
            n_checked    = 0;
            fail_count   <= 0;
            pending      <= 0;
            checked      <= 0;
            awaited.delete();
        end
        else begin
            // Compare a strobed result with the oldest outstanding one
            if (result_valid) begin
                got = {result_kind, status, out_op, out_id, out_onoff, out_tid,
                       out_transition, out_delay, copy_index, last};
                n_checked++;
                if (awaited.size() == 0) begin
                    $display("%0t: result expected none, got kind %0h tid %0h copy %0h",
                             $time, got.kind, got.tid, got.copy);
                    errs++;
                end
                else begin
                    want = awaited.pop_front();
                    check_field("result_kind", 32'(want.kind), 32'(got.kind));
                    check_field("status", 32'(want.stat), 32'(got.stat));
                    check_field("out_op", 32'(want.op), 32'(got.op));
                    check_field("out_id", 32'(want.id), 32'(got.id));
                    check_field("out_onoff", 32'(want.onoff), 32'(got.onoff));
                    check_field("out_tid", 32'(want.tid), 32'(got.tid));
                    check_field("out_transition", 32'(want.transition),
                                32'(got.transition));
                    check_field("out_delay", 32'(want.delay), 32'(got.delay));
                    check_field("copy_index", 32'(want.copy), 32'(got.copy));
                    check_field("last", 32'(want.last), 32'(got.last));
                end
            end

            // Track register writes, check register reads
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (paddr[ADDR_W-1:2])
                        REG_REPEAT_COUNT:    rpt_count    = pwdata[3:0];
                        REG_REPEAT_INTERVAL: rpt_interval = pwdata[15:0];
                        default: ;
                    endcase
                end
                else begin
                    case (paddr[ADDR_W-1:2])
                        REG_REPEAT_COUNT:    reg_value = DATA_W'(rpt_count);
                        REG_REPEAT_INTERVAL: reg_value = DATA_W'(rpt_interval);
                        default:             reg_value = prdata;
                    endcase
                    check_field("prdata", reg_value, prdata);
                end
            end

            // Predict the results of an accepted command transfer
            if (start && !busy) begin
                if (req_type == REQ_PUBLISH)
                    place_copies(now_ms, msg_op, target_id, onoff, transition_ms, delay_ms);
                else
                    release_due(now_ms);
            end

            fail_count <= errs;
            pending    <= awaited.size();
            checked    <= n_checked;
        end
    end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the timed repeat publish queue.
// A directed opening covers due-at-zero, nothing-due ticks, a full table and
// dropped requests and due-time wrap; then several phases of random
// publish/tick traffic follow under varied register settings, with random
// sender gaps. The checker does all comparing.
// ----------------------------------------------------------------------------
module tb;
    import trpq_pkg::*;

    localparam int SETTLE_CYCLES = 25;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 42;
    localparam logic [ADDR_W-1:0] ADDR_COUNT    = {REG_REPEAT_COUNT, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_INTERVAL = {REG_REPEAT_INTERVAL, 2'b00};

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              start         = 1'b0;
    logic              req_type      = REQ_TICK;
    logic [31:0]       now_ms        = '0;
    logic [1:0]        msg_op        = '0;
    logic [15:0]       target_id     = '0;
    logic              onoff         = 1'b0;
    logic [15:0]       transition_ms = '0;
    logic [15:0]       delay_ms      = '0;
    logic              psel          = 1'b0;
    logic              penable       = 1'b0;
    logic              pwrite        = 1'b0;
    logic [ADDR_W-1:0] paddr         = '0;
    logic [DATA_W-1:0] pwdata        = '0;

    logic              busy;
    logic              result_valid;
    logic              result_kind;
    logic              status;
    logic [1:0]        out_op;
    logic [15:0]       out_id;
    logic              out_onoff;
    logic [7:0]        out_tid;
    logic [15:0]       out_transition;
    logic [15:0]       out_delay;
    logic [3:0]        copy_index;
    logic              last;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int                fail_count;
    int                pending;
    int                checked;

    int                n_publish;
    int                n_tick;
    int                n_settings;
    int                idle_max;
    int                roll;
    int                step_lim;
    logic [31:0]       clock_ms;
    logic [15:0]       cur_interval;

    always #10 clk = ~clk;

    timed_repeat_publish_queue dut (.*);
    publish_queue_checker chk (.*);

    // Optional sender gap, then hold the command until it is taken
    task automatic send_cmd(input logic kind, input logic [31:0] now, input logic [1:0] op,
                            input logic [15:0] id, input logic oo,
                            input logic [15:0] tr, input logic [15:0] dl);
        int gap;
        gap = $urandom_range(0, idle_max);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start         <= 1'b1;
        req_type      <= kind;
        now_ms        <= now;
        msg_op        <= op;
        target_id     <= id;
        onoff         <= oo;
        transition_ms <= tr;
        delay_ms      <= dl;
        do @(posedge clk); while (busy);
        if (kind == REQ_PUBLISH)
            n_publish++;
        else
            n_tick++;
    endtask

    task automatic publish_rand(input logic [31:0] now);
        send_cmd(REQ_PUBLISH, now, 2'($urandom_range(0, 3)), 16'($urandom),
                 1'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // Tick carries random content on the fields it does not use
    task automatic tick_at(input logic [31:0] now);
        send_cmd(REQ_TICK, now, 2'($urandom_range(0, 3)), 16'($urandom),
                 1'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // Drop start, wait out every outstanding result and a silent scan
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register transfer; leaves the bus in the access phase for the caller
    task automatic reg_access(input logic wr, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    // Write both registers in random order with junk upper bits, read them back
    task automatic set_config(input logic [3:0] cnt, input logic [15:0] ivl);
        logic [DATA_W-1:0] junk;
        junk = $urandom;
        if ($urandom_range(0, 1) == 1) begin
            reg_access(1'b1, ADDR_COUNT, {junk[DATA_W-1:4], cnt});
            reg_access(1'b1, ADDR_INTERVAL, {junk[DATA_W-1:16], ivl});
        end
        else begin
            reg_access(1'b1, ADDR_INTERVAL, {junk[DATA_W-1:16], ivl});
            reg_access(1'b1, ADDR_COUNT, {junk[DATA_W-1:4], cnt});
        end
        reg_access(1'b0, ADDR_COUNT, '0);
        reg_access(1'b0, ADDR_INTERVAL, '0);
        psel         <= 1'b0;
        penable      <= 1'b0;
        cur_interval = ivl;
        n_settings++;
    endtask

    // Hard stop in case the block hangs
    initial begin
        #4_000_000;
        $display("timed_repeat_publish_queue: mismatch");
        $finish;
    end

    initial begin
        n_publish    = 0;
        n_tick       = 0;
        n_settings   = 1;
        idle_max     = 17;
        cur_interval = REPEAT_INTERVAL_RST;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: copies due at 0, 20 and 40
        send_cmd(REQ_PUBLISH, 32'd0, 2'd0, 16'h1234, 1'b1, 16'd100, 16'd7);
        tick_at(32'd0);
        tick_at(32'd19);
        tick_at(32'd40);
        send_cmd(REQ_PUBLISH, 32'd100, 2'd1, 16'h0001, 1'b0, 16'd0, 16'd0);
        send_cmd(REQ_PUBLISH, 32'd100, 2'd2, 16'h8000, 1'b1, 16'h8000, 16'h8000);
        send_cmd(REQ_PUBLISH, 32'd100, 2'd3, 16'h7FFF, 1'b0, 16'h7FFF, 16'h7FFF);
        tick_at(32'hFFFF_FFFF);
        drain();

        // Sixteen copies fill the table, the next request drops them all
        set_config(4'd15, 16'd0);
        send_cmd(REQ_PUBLISH, 32'hFFFF_FFFF, 2'd3, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF);
        send_cmd(REQ_PUBLISH, 32'd0, 2'd0, 16'h0000, 1'b0, 16'h0000, 16'h0000);
        tick_at(32'hFFFF_FFFE);
        tick_at(32'hFFFF_FFFF);
        drain();

        // Due times wrap past the top of the millisecond counter
        set_config(4'd15, 16'hFFFF);
        publish_rand(32'hFFFF_0000);
        tick_at(32'h0001_0000);
        tick_at(32'hFFFF_FFFF);
        drain();

        // Fourth request places one copy and then drops
        set_config(4'd4, 16'd1);
        publish_rand(32'd500);
        publish_rand(32'd500);
        publish_rand(32'd500);
        publish_rand(32'd500);
        tick_at(32'd502);
        tick_at(32'hFFFF_FFFF);
        drain();

        // Random phases: mostly ordered traffic on a rising clock, some noise
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       set_config(4'd0, 16'($urandom_range(1, 100)));
                1:       set_config(4'd15, 16'hFFFF);
                2:       set_config(4'd0, 16'd0);
                default: set_config(4'($urandom_range(0, 15)),
                                    ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                                : 16'($urandom_range(0, 50)));
            endcase
            idle_max = ($urandom_range(0, 3) == 0) ? 0 : 17;
            clock_ms = (ph == 4) ? 32'hFFFF_FFFF - $urandom_range(0, 3000) : $urandom;
            step_lim = 2 * int'(cur_interval) + 3;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < 8) begin
                    if ($urandom_range(0, 1) == 1)
                        publish_rand($urandom);
                    else
                        tick_at($urandom);
                end
                else if (roll < 62) begin
                    publish_rand(clock_ms);
                end
                else begin
                    clock_ms = clock_ms + $urandom_range(0, step_lim);
                    tick_at(clock_ms);
                end
            end
            tick_at(32'hFFFF_FFFF);
            drain();
        end

        $display("Covered %0d commands (%0d publish, %0d tick) under %0d register settings;",
                 n_publish + n_tick, n_publish, n_tick, n_settings);
        $display("%0d results compared.", checked);
        if (fail_count == 0)
            $display("timed_repeat_publish_queue: match");
        else
            $display("timed_repeat_publish_queue: mismatch");
        $finish;
    end

endmodule

// ===== timed_repeat_publish_queue.f =====
+incdir+rtl/core
rtl/core/trpq_pkg.sv
rtl/core/timed_repeat_publish_queue.sv
sim/publish_queue_checker.sv
sim/tb.sv
